/* hdl/ab2lp_pkg.sv */
// shared constants and types for the annex b to length-prefix converter
package ab2lp_pkg;

  localparam int unsigned PosBits   = 24;
  localparam int unsigned FieldBits = 24;
  localparam int unsigned CfgAddrBits = 8;
  localparam int unsigned TypeBits  = 5;
  localparam int unsigned CodeLen   = 4;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);
  localparam int unsigned MaxPush   = 3;

  localparam logic [23:0] WindowReset = 24'hFFFFFE;
  localparam logic [23:0] ZeroRun     = 24'h000000;
  localparam logic [7:0]  StartByte   = 8'h01;
  localparam logic [7:0]  TypeMask    = 8'h1F;

  localparam logic [TypeBits-1:0] NalSps = TypeBits'(7);
  localparam logic [TypeBits-1:0] NalPps = TypeBits'(8);

  localparam logic [CfgAddrBits-1:0] RegAvcOutput   = CfgAddrBits'(0);
  localparam logic [CfgAddrBits-1:0] RegKeepHeaders = CfgAddrBits'(1);
  localparam logic [CfgAddrBits-1:0] RegSingleNal   = CfgAddrBits'(2);
  localparam logic [CfgAddrBits-1:0] RegHeaderBytes = CfgAddrBits'(3);

  typedef enum logic {
    RES_PATCH   = 1'b0,
    RES_SUMMARY = 1'b1
  } result_kind_e;

  // a patch carries position and length, a summary carries trim and total
  typedef struct packed {
    result_kind_e         kind;
    logic [PosBits-1:0]   val_a;
    logic [PosBits-1:0]   val_b;
  } res_entry_t;

endpackage

/* hdl/annexb_to_length_prefix_nal_top.sv */
// annex b start code scanner that produces length-prefix patches per buffer
//
// Usage: bytes of one encoded buffer enter on the s_axis channel, one byte
// per transaction, with s_axis_tlast on the final byte. For each kept NAL
// unit (avc output on) the block returns a patch on m_axis (tuser 0): the
// offset of the four start code bytes and the big-endian length to write
// over them. After the last byte it returns a summary (tuser 1, tlast 1)
// with the leading bytes to trim and the buffer size. Registers are written
// on the always-ready cfg channel; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// Throughput: one byte per cycle while s_axis_tready is high. Each byte is
// handled by one pass of logic from the scan state into an 8-entry result
// queue that registers its results. A byte can cause up to three results,
// so s_axis_tready drops when fewer than three queue slots are free; a
// stalled receiver thus stops input before overflow and nothing is lost.
// Reset: clears the registers to zero, empties the queue and the scan state.
module annexb_to_length_prefix_nal_top
  import ab2lp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [FieldBits-1:0]   cfg_data_i,
  // input bytes
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // data_byte
  input  logic                   s_axis_tlast,   // end_of_buffer
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // patch_position [23:0], patch_length [47:24], trim_start [71:48],
  // total_bytes [95:72]
  output logic [4*FieldBits-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,   // result_kind
  output logic                   m_axis_tlast    // last
);

  // configuration
  logic                 avc_output_q, keep_headers_q, single_nal_q;
  logic [FieldBits-1:0] header_bytes_q;

  // scan state
  logic [23:0]         window_q, window_d;
  logic [PosBits-1:0]  byte_pos_q, byte_pos_d;
  logic [PosBits-1:0]  nal_begin_q, nal_begin_d;
  logic [TypeBits-1:0] cur_type_q, cur_type_d;
  logic                type_valid_q, type_valid_d;
  logic                pending_q, pending_d;
  logic [PosBits-1:0]  pend_end_q, pend_end_d;
  logic [TypeBits-1:0] pend_type_q, pend_type_d;
  logic [PosBits-1:0]  trim_q, trim_d;
  logic                scan_done_q, scan_done_d;

  // result queue
  res_entry_t             fifo_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrBits:0]   count_q;
  res_entry_t             push_data [MaxPush];
  logic [1:0]             push_n;

  logic s_fire, m_fire;
  logic [PosBits-1:0] pos_dist, total;
  logic [PosBits:0]   len_rhs;
  logic               hdr_now, prev_hdr;
  logic [7:0]         in_byte;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (count_q <= (FifoPtrBits+1)'(FifoDepth - MaxPush));
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign m_fire        = m_axis_tvalid & m_axis_tready;
  assign in_byte       = s_axis_tdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avc_output_q   <= 1'b0;
      keep_headers_q <= 1'b0;
      single_nal_q   <= 1'b0;
      header_bytes_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        RegAvcOutput:   avc_output_q   <= cfg_data_i[0];
        RegKeepHeaders: keep_headers_q <= cfg_data_i[0];
        RegSingleNal:   single_nal_q   <= cfg_data_i[0];
        RegHeaderBytes: header_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    window_d     = window_q;
    byte_pos_d   = byte_pos_q;
    nal_begin_d  = nal_begin_q;
    cur_type_d   = cur_type_q;
    type_valid_d = type_valid_q;
    pending_d    = pending_q;
    pend_end_d   = pend_end_q;
    pend_type_d  = pend_type_q;
    trim_d       = trim_q;
    scan_done_d  = scan_done_q;
    push_n       = 2'd0;
    for (int k = 0; k < MaxPush; k++) begin
      push_data[k] = '{kind: RES_PATCH, val_a: '0, val_b: '0};
    end

    pos_dist = byte_pos_q - pend_end_q;
    hdr_now  = (pend_type_q == NalSps) || (pend_type_q == NalPps);
    prev_hdr = (cur_type_q == NalSps) || (cur_type_q == NalPps);
    len_rhs  = {1'b0, nal_begin_q} + (PosBits+1)'(CodeLen - 1);
    total    = byte_pos_q + PosBits'(1);

    if (s_fire) begin
      if (avc_output_q && !scan_done_q) begin
        if (pending_q) begin
          if (pos_dist == PosBits'(1)) begin
            pend_type_d = TypeBits'(in_byte & TypeMask);
          end
          // start code confirmed once the fourth byte after it arrives
          if (pos_dist == PosBits'(CodeLen)) begin
            pending_d    = 1'b0;
            cur_type_d   = pend_type_q;
            type_valid_d = 1'b1;
            if (single_nal_q) begin
              scan_done_d = 1'b1;
              if (hdr_now) begin
                trim_d      = PosBits'(header_bytes_q);
                nal_begin_d = pend_end_q + PosBits'(header_bytes_q) + PosBits'(1);
              end else begin
                nal_begin_d = pend_end_q + PosBits'(1);
              end
            end else begin
              if (type_valid_q) begin
                if (prev_hdr && !keep_headers_q) begin
                  trim_d = pend_end_q - PosBits'(CodeLen - 1);
                end else begin
                  push_data[0].kind  = RES_PATCH;
                  push_data[0].val_a = nal_begin_q - PosBits'(CodeLen);
                  push_data[0].val_b = ({1'b0, pend_end_q} >= len_rhs) ?
                                       PosBits'({1'b0, pend_end_q} - len_rhs) : '0;
                  push_n = 2'd1;
                end
              end
              nal_begin_d = pend_end_q + PosBits'(1);
            end
          end
        end
        window_d = {window_q[15:0], in_byte};
        if (!scan_done_d && window_q == ZeroRun && in_byte == StartByte) begin
          pending_d  = 1'b1;
          pend_end_d = byte_pos_q;
        end
      end

      if (s_axis_tlast) begin
        if (avc_output_q && type_valid_d) begin
          push_data[push_n].kind  = RES_PATCH;
          push_data[push_n].val_a = nal_begin_d - PosBits'(CodeLen);
          push_data[push_n].val_b = (total >= nal_begin_d) ? (total - nal_begin_d) : '0;
          push_n = push_n + 2'd1;
        end
        push_data[push_n].kind  = RES_SUMMARY;
        push_data[push_n].val_a = trim_d;
        push_data[push_n].val_b = total;
        push_n = push_n + 2'd1;
        // back to the idle scan state for the next buffer
        window_d     = WindowReset;
        byte_pos_d   = '0;
        nal_begin_d  = '0;
        cur_type_d   = '0;
        type_valid_d = 1'b0;
        pending_d    = 1'b0;
        pend_end_d   = '0;
        pend_type_d  = '0;
        trim_d       = '0;
        scan_done_d  = 1'b0;
      end else begin
        byte_pos_d = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WindowReset;
      byte_pos_q   <= '0;
      nal_begin_q  <= '0;
      cur_type_q   <= '0;
      type_valid_q <= 1'b0;
      pending_q    <= 1'b0;
      pend_end_q   <= '0;
      pend_type_q  <= '0;
      trim_q       <= '0;
      scan_done_q  <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      window_q     <= window_d;
      byte_pos_q   <= byte_pos_d;
      nal_begin_q  <= nal_begin_d;
      cur_type_q   <= cur_type_d;
      type_valid_q <= type_valid_d;
      pending_q    <= pending_d;
      pend_end_q   <= pend_end_d;
      pend_type_q  <= pend_type_d;
      trim_q       <= trim_d;
      scan_done_q  <= scan_done_d;
      wr_ptr_q     <= wr_ptr_q + FifoPtrBits'(push_n);
      rd_ptr_q     <= rd_ptr_q + FifoPtrBits'(m_fire);
      count_q      <= count_q + (FifoPtrBits+1)'(push_n) - (FifoPtrBits+1)'(m_fire);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxPush; k++) begin
      if (2'(k) < push_n) begin
        fifo_q[wr_ptr_q + FifoPtrBits'(k)] <= push_data[k];
      end
    end
  end

  res_entry_t head;
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = (head.kind == RES_SUMMARY);
  assign m_axis_tdata  = (head.kind == RES_SUMMARY) ?
    {FieldBits'(head.val_b), FieldBits'(head.val_a), {(2*FieldBits){1'b0}}} :
    {{(2*FieldBits){1'b0}}, FieldBits'(head.val_b), FieldBits'(head.val_a)};

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FifoPtrBits+1)'(FifoDepth))
    else $error("result queue overflow");

  // a buffer end returns the scan state to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> (byte_pos_q == '0 && !type_valid_q && !pending_q
                                  && !scan_done_q))
    else $error("scan state not cleared after buffer end");

  // a buffer end always leaves a summary to deliver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no result after buffer end");

  // with a full-ish queue no byte is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > (FifoPtrBits+1)'(FifoDepth - MaxPush)) |-> !s_axis_tready)
    else $error("input taken without queue room");

endmodule
